@@ design/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Shared constants, state codes and store request/response types.
// ----------------------------------------------------------------------------
`default_nettype none
package bba_pkg;

  localparam int MIN_ORD  = 12;
  localparam int MAX_ORD  = 20;
  localparam int TOP_REL  = MAX_ORD - MIN_ORD;
  localparam int PG_W     = TOP_REL;
  localparam int NPAGE    = 1 << PG_W;
  localparam int ORD_W    = 4;
  localparam int STP_W    = 32;
  localparam int ADDR_W   = 20;
  localparam int SIZE_W   = 21;

  localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(1) << MAX_ORD;
  localparam logic [ORD_W-1:0]  TOP_ORD    = ORD_W'(TOP_REL);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SIZE  = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_SPLIT = 9'b000001000,
    S_FRD   = 9'b000010000,
    S_FORD  = 9'b000100000,
    S_FBUD  = 9'b001000000,
    S_FCHK  = 9'b010000000,
    S_FINS  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic [PG_W-1:0]  rd_addr;
    logic [PG_W-1:0]  wr_addr;
    logic             wr_free_en;
    logic             wr_free;
    logic             wr_ord_en;
    logic [ORD_W-1:0] wr_ord;
    logic             wr_stp_en;
    logic [STP_W-1:0] wr_stp;
  } st_req_t;

  typedef struct packed {
    logic             free;
    logic [ORD_W-1:0] ord;
    logic [STP_W-1:0] stp;
  } st_rsp_t;

endpackage
`default_nettype wire

@@ design/bba_store.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator page table
// Per-page free flag, order and insertion stamp; one read, one write a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module bba_store (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bba_pkg::st_req_t req,
  output bba_pkg::st_rsp_t      rsp
);

  logic [bba_pkg::ORD_W-1:0] mem_ord [bba_pkg::NPAGE];
  logic [bba_pkg::STP_W-1:0] mem_stp [bba_pkg::NPAGE];
  logic [bba_pkg::NPAGE-1:0] ord_vld_r;
  logic [bba_pkg::NPAGE-1:0] free_r;
  logic                      stp0_vld_r;

  logic [bba_pkg::ORD_W-1:0] ord_q_r;
  logic [bba_pkg::STP_W-1:0] stp_q_r;
  logic [bba_pkg::PG_W-1:0]  rd_q_r;
  logic                      ordv_q_r;
  logic                      stpv_q_r;
  logic                      free_q_r;

  always_ff @(posedge clk) begin
    if (req.wr_ord_en) begin
      mem_ord[req.wr_addr] <= req.wr_ord;
    end
    if (req.wr_stp_en) begin
      mem_stp[req.wr_addr] <= req.wr_stp;
    end
    ord_q_r  <= mem_ord[req.rd_addr];
    stp_q_r  <= mem_stp[req.rd_addr];
    rd_q_r   <= req.rd_addr;
    ordv_q_r <= ord_vld_r[req.rd_addr];
    stpv_q_r <= (req.rd_addr != '0) | stp0_vld_r;
    free_q_r <= free_r[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_vld_r  <= '0;
      free_r     <= bba_pkg::NPAGE'(1);
      stp0_vld_r <= 1'b0;
    end else begin
      if (req.wr_ord_en) begin
        ord_vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.wr_free_en) begin
        free_r[req.wr_addr] <= req.wr_free;
      end
      if (req.wr_stp_en && req.wr_addr == '0) begin
        stp0_vld_r <= 1'b1;
      end
    end
  end

  // unwritten orders and the page-0 stamp read as their reset contents
  always_comb begin
    rsp.free = free_q_r;
    rsp.ord  = ordv_q_r ? ord_q_r :
               (rd_q_r == '0 ? bba_pkg::TOP_ORD : '0);
    rsp.stp  = stpv_q_r ? stp_q_r : '0;
  end

endmodule
`default_nettype wire

@@ design/buddy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator
// 1 MiB region of 4 KiB pages; allocate and free requests, one result each.
// ----------------------------------------------------------------------------
// channel   ports                                          handshake
// request   in_operation, in_request_size, in_block_address  start & !busy
// result    out_result_address, out_status                 out_valid, 1 cycle
//
// Allocate: find the order for the size, then scan every page once per order
// (up to 9 orders, from the needed order upward), then split down to size.
// Free: read the order, then check the buddy and merge at each level until
// merging stops or the top order is reached, then insert the merged block.
// Reset is synchronous; the result cannot stall.
`default_nettype none
module buddy_block_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_operation,
  input  wire logic [bba_pkg::SIZE_W-1:0]  in_request_size,
  input  wire logic [bba_pkg::ADDR_W-1:0]  in_block_address,
  output logic                             out_valid,
  output logic [bba_pkg::ADDR_W-1:0]       out_result_address,
  output logic                             out_status
);

  bba_pkg::state_t state_r, state_nxt;
  bba_pkg::st_req_t req;
  bba_pkg::st_rsp_t rsp;

  logic [bba_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [bba_pkg::ORD_W-1:0]  need_r, need_nxt;
  logic [bba_pkg::ORD_W-1:0]  k_r, k_nxt;
  logic [bba_pkg::PG_W:0]     cnt_r, cnt_nxt;
  logic                       cmp_v_r, cmp_v_nxt;
  logic [bba_pkg::PG_W-1:0]   cmp_pg_r, cmp_pg_nxt;
  logic                       best_v_r, best_v_nxt;
  logic [bba_pkg::PG_W-1:0]   best_pg_r, best_pg_nxt;
  logic [bba_pkg::STP_W-1:0]  best_stp_r, best_stp_nxt;
  logic [bba_pkg::PG_W-1:0]   pg_r, pg_nxt;
  logic [bba_pkg::ORD_W-1:0]  rel_r, rel_nxt;
  logic [bba_pkg::STP_W-1:0]  stamp_r, stamp_nxt;
  logic                       ov_r, ov_nxt;
  logic [bba_pkg::ADDR_W-1:0] oa_r, oa_nxt;
  logic                       os_r, os_nxt;

  logic                       hit;
  logic [bba_pkg::ORD_W-1:0]  kd;
  logic [bba_pkg::PG_W-1:0]   bud_bit;
  logic [4:0]                 sh;

  bba_store u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  assign kd      = k_r - bba_pkg::ORD_W'(1);
  assign bud_bit = bba_pkg::PG_W'(1) << rel_r[2:0];
  assign sh      = 5'(need_r) + 5'(bba_pkg::MIN_ORD);
  assign hit     = cmp_v_r && rsp.free && rsp.ord == k_r &&
                   (!best_v_r || rsp.stp > best_stp_r);

  always_comb begin
    state_nxt    = state_r;
    size_nxt     = size_r;
    need_nxt     = need_r;
    k_nxt        = k_r;
    cnt_nxt      = cnt_r;
    cmp_v_nxt    = 1'b0;
    cmp_pg_nxt   = cmp_pg_r;
    best_v_nxt   = best_v_r;
    best_pg_nxt  = best_pg_r;
    best_stp_nxt = best_stp_r;
    pg_nxt       = pg_r;
    rel_nxt      = rel_r;
    stamp_nxt    = stamp_r;
    ov_nxt       = 1'b0;
    oa_nxt       = oa_r;
    os_nxt       = os_r;
    req          = '0;
    req.rd_addr  = pg_r;

    unique case (state_r)
      bba_pkg::S_IDLE: begin
        if (start) begin
          size_nxt = in_request_size;
          need_nxt = '0;
          pg_nxt   = in_block_address[bba_pkg::ADDR_W-1:bba_pkg::MIN_ORD];
          state_nxt = (in_operation == bba_pkg::OP_FREE) ? bba_pkg::S_FRD
                                                         : bba_pkg::S_SIZE;
        end
      end
      bba_pkg::S_SIZE: begin
        if (size_r == '0 || size_r > bba_pkg::SIZE_LIMIT) begin
          ov_nxt = 1'b1; oa_nxt = '0; os_nxt = bba_pkg::ST_FAIL;
          state_nxt = bba_pkg::S_IDLE;
        end else if (need_r < bba_pkg::TOP_ORD &&
                     (bba_pkg::SIZE_W'(1) << sh) < size_r) begin
          need_nxt = need_r + bba_pkg::ORD_W'(1);
        end else begin
          k_nxt      = need_r;
          cnt_nxt    = '0;
          best_v_nxt = 1'b0;
          state_nxt  = bba_pkg::S_SCAN;
        end
      end
      bba_pkg::S_SCAN: begin
        req.rd_addr = cnt_r[bba_pkg::PG_W-1:0];
        if (!cnt_r[bba_pkg::PG_W]) begin
          cnt_nxt    = cnt_r + 1'b1;
          cmp_v_nxt  = 1'b1;
          cmp_pg_nxt = cnt_r[bba_pkg::PG_W-1:0];
        end
        if (hit) begin
          best_v_nxt   = 1'b1;
          best_pg_nxt  = cmp_pg_r;
          best_stp_nxt = rsp.stp;
        end
        if (cmp_v_r && cmp_pg_r == '1) begin
          cmp_v_nxt = 1'b0;
          if (best_v_nxt) begin
            pg_nxt         = best_pg_nxt;
            req.wr_addr    = best_pg_nxt;
            req.wr_free_en = 1'b1;
            req.wr_free    = 1'b0;
            state_nxt      = bba_pkg::S_SPLIT;
          end else if (k_r == bba_pkg::TOP_ORD) begin
            ov_nxt = 1'b1; oa_nxt = '0; os_nxt = bba_pkg::ST_FAIL;
            state_nxt = bba_pkg::S_IDLE;
          end else begin
            k_nxt      = k_r + bba_pkg::ORD_W'(1);
            cnt_nxt    = '0;
            best_v_nxt = 1'b0;
          end
        end
      end
      bba_pkg::S_SPLIT: begin
        if (k_r > need_r) begin
          // free the right half at the next order down
          k_nxt          = kd;
          req.wr_addr    = pg_r + (bba_pkg::PG_W'(1) << kd[2:0]);
          req.wr_free_en = 1'b1;
          req.wr_free    = 1'b1;
          req.wr_ord_en  = 1'b1;
          req.wr_ord     = kd;
          req.wr_stp_en  = 1'b1;
          req.wr_stp     = stamp_r;
          stamp_nxt      = stamp_r + 1'b1;
        end else begin
          req.wr_addr   = pg_r;
          req.wr_ord_en = 1'b1;
          req.wr_ord    = need_r;
          ov_nxt = 1'b1;
          oa_nxt = {pg_r, {bba_pkg::MIN_ORD{1'b0}}};
          os_nxt = bba_pkg::ST_OK;
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_FRD: begin
        state_nxt = bba_pkg::S_FORD;
      end
      bba_pkg::S_FORD: begin
        rel_nxt   = (rsp.ord > bba_pkg::TOP_ORD) ? bba_pkg::TOP_ORD : rsp.ord;
        state_nxt = bba_pkg::S_FBUD;
      end
      bba_pkg::S_FBUD: begin
        req.rd_addr = pg_r ^ bud_bit;
        state_nxt   = (rel_r == bba_pkg::TOP_ORD) ? bba_pkg::S_FINS
                                                  : bba_pkg::S_FCHK;
      end
      bba_pkg::S_FCHK: begin
        if (rsp.free && rsp.ord == rel_r) begin
          // absorb the buddy and climb one order
          req.wr_addr    = pg_r ^ bud_bit;
          req.wr_free_en = 1'b1;
          req.wr_free    = 1'b0;
          pg_nxt         = pg_r & ~bud_bit;
          rel_nxt        = rel_r + bba_pkg::ORD_W'(1);
          state_nxt      = bba_pkg::S_FBUD;
        end else begin
          state_nxt = bba_pkg::S_FINS;
        end
      end
      bba_pkg::S_FINS: begin
        req.wr_addr    = pg_r;
        req.wr_free_en = 1'b1;
        req.wr_free    = 1'b1;
        req.wr_ord_en  = 1'b1;
        req.wr_ord     = rel_r;
        req.wr_stp_en  = 1'b1;
        req.wr_stp     = stamp_r;
        stamp_nxt      = stamp_r + 1'b1;
        ov_nxt = 1'b1; oa_nxt = '0; os_nxt = bba_pkg::ST_OK;
        state_nxt = bba_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_IDLE;
      stamp_r <= bba_pkg::STP_W'(1);
      ov_r    <= 1'b0;
      cmp_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stamp_r <= stamp_nxt;
      ov_r    <= ov_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    need_r     <= need_nxt;
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    cmp_pg_r   <= cmp_pg_nxt;
    best_v_r   <= best_v_nxt;
    best_pg_r  <= best_pg_nxt;
    best_stp_r <= best_stp_nxt;
    pg_r       <= pg_nxt;
    rel_r      <= rel_nxt;
    oa_r       <= oa_nxt;
    os_r       <= os_nxt;
  end

  assign busy               = (state_r != bba_pkg::S_IDLE);
  assign out_valid          = ov_r;
  assign out_result_address = oa_r;
  assign out_status         = os_r;

endmodule
`default_nettype wire

@@ design/bba_checker.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator port checker
// Timing and result rules seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module bba_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       out_valid,
  input wire logic [bba_pkg::ADDR_W-1:0] out_result_address,
  input wire logic                       out_status
);

  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request not taken");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> out_result_address == '0)
    else $error("failed result carries an address");

  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid)) else $error("reset not idle");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_result_address(out_result_address),
  .out_status        (out_status)
);
`default_nettype wire
